// ===== sv/fsc_pkg.sv =====
package fsc_pkg;

  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 7;
  localparam int NUM_W    = 31;
  localparam int STATUS_W = 3;
  localparam int ARG_W    = 8;
  localparam int PROD_W   = NUM_W + 4;

  localparam logic [PROD_W-1:0] NUM_MAX = PROD_W'(32'h7FFF_FFFF);
  localparam logic [PROD_W-1:0] RADIX   = PROD_W'(10);

  localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_S      = 8'h73;
  localparam logic [CHAR_W-1:0] CH_I      = 8'h49;
  localparam logic [CHAR_W-1:0] CH_L      = 8'h4C;

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_PCT,
    MODE_NUM1,
    MODE_FLAGS,
    MODE_WIDTH,
    MODE_STAR,
    MODE_STARNUM,
    MODE_TYPE
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_UNUSED,
    ST_UNTERM,
    ST_RANGE,
    ST_ZERO,
    ST_NODOLLAR,
    ST_BADTYPE,
    ST_TOOFEW
  } status_t;

  typedef enum logic [1:0] {
    POS_NONE,
    POS_IMPL,
    POS_EXPL
  } pos_kind_t;

endpackage

// ===== sv/fsc_in_if.sv =====
interface fsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [fsc_pkg::CHAR_W-1:0]  char_code;
  logic                        end_mark;

  modport source(output valid, char_code, end_mark, input ready);
  modport sink(input valid, char_code, end_mark, output ready);
endinterface

// ===== sv/fsc_out_if.sv =====
interface fsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [fsc_pkg::STATUS_W-1:0] status;
  logic                         required_known;
  logic [fsc_pkg::COUNT_W-1:0]  required_count;

  modport source(output valid, status, required_known, required_count, input ready);
  modport sink(input valid, status, required_known, required_count, output ready);
endinterface

// ===== sv/fsc_cfg_if.sv =====
interface fsc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fsc_pkg::COUNT_W-1:0] arg_count;

  modport source(output valid, arg_count, input ready);
  modport sink(input valid, arg_count, output ready);
endinterface

// ===== sv/format_spec_checker.sv =====
// Channel  Dir  Word
// chars    in   char_code[7:0], end_mark
// result   out  status[2:0], required_known, required_count[6:0]
// cfg      in   arg_count[6:0]
//
// One char word per cycle; the parser state registers take each word in the
// cycle it is accepted, so words may arrive back to back.
// An end word loads the result register at its accepting edge and clears the
// parser; the result is offered from the next cycle on.
// chars stalls only while a result is held and result.ready is low.
// cfg is always ready. rst is synchronous; arg_count resets to 1.
module format_spec_checker (
  input logic       clk,
  input logic       rst,
  fsc_in_if.sink    chars,
  fsc_out_if.source result,
  fsc_cfg_if.sink   cfg
);
  import fsc_pkg::*;

  logic [COUNT_W-1:0] arg_count;
  mode_t              mode, mode_next;
  logic [NUM_W-1:0]   num, num_next;
  logic [NUM_W-1:0]   arg_pos, arg_pos_next;
  logic               arg_pos_valid, arg_pos_valid_next;
  logic [NUM_W-1:0]   width_pos, width_pos_next;
  pos_kind_t          width_kind, width_kind_next;
  logic [ARG_W-1:0]   next_arg, next_arg_next;
  logic [COUNT_W-1:0] tally, tally_next;
  logic               tally_known, tally_known_next;
  status_t            err_code, err_code_next;

  logic               out_valid;
  status_t            out_status;
  logic               out_known;
  logic [COUNT_W-1:0] out_count;

  logic               acc, acc_char, acc_end;
  logic [CHAR_W-1:0]  c;
  logic               is_dig, dig_ovf, bad_type;
  logic [PROD_W-1:0]  dig_sum;
  logic [NUM_W-1:0]   dig_first;

  logic               ty_apos_valid;
  pos_kind_t          ty_wkind;
  logic [ARG_W-1:0]   na1, na2;
  logic [COUNT_W-1:0] tal1, tal2;
  logic               kn1, kn2;
  status_t            e1, e2;

  assign chars.ready = !out_valid || result.ready;
  assign cfg.ready   = 1'b1;
  assign acc         = chars.valid && chars.ready;
  assign acc_end     = acc && chars.end_mark;
  assign acc_char    = acc && !chars.end_mark && (err_code == ST_OK);
  assign c           = chars.char_code;

  assign is_dig    = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dig_sum   = ({4'b0, num} * RADIX) + PROD_W'(c[3:0]);
  assign dig_ovf   = dig_sum > NUM_MAX;
  assign dig_first = NUM_W'(c[3:0]);
  assign bad_type  = !((c == CH_S) || (c == CH_I) || (c == CH_L));

  // position context seen by the type byte
  always_comb begin
    ty_apos_valid = (mode == MODE_PCT) ? 1'b0 : arg_pos_valid;
    unique case (mode)
      MODE_PCT:  ty_wkind = POS_NONE;
      MODE_STAR: ty_wkind = POS_IMPL;
      default:   ty_wkind = width_kind;
    endcase
  end

  // width argument first, then the main argument
  always_comb begin
    na1  = next_arg;
    tal1 = tally;
    kn1  = tally_known;
    e1   = ST_OK;
    case (ty_wkind)
      POS_EXPL: begin
        if (width_pos > NUM_W'(arg_count)) begin
          e1 = ST_TOOFEW;
        end else begin
          kn1  = 1'b0;
          tal1 = '0;
        end
      end
      POS_IMPL: begin
        na1 = next_arg + ARG_W'(1);
        if (na1 > ARG_W'(arg_count)) begin
          e1 = ST_TOOFEW;
        end else if (tally_known) begin
          tal1 = tally + COUNT_W'(1);
        end
      end
      default: ;
    endcase

    na2  = na1;
    tal2 = tal1;
    kn2  = kn1;
    e2   = e1;
    if (e1 == ST_OK) begin
      if (ty_apos_valid) begin
        if (arg_pos > NUM_W'(arg_count)) begin
          e2 = ST_TOOFEW;
        end else begin
          kn2  = 1'b0;
          tal2 = '0;
        end
      end else begin
        na2 = na1 + ARG_W'(1);
        if (na2 > ARG_W'(arg_count)) begin
          e2 = ST_TOOFEW;
        end else if (kn1) begin
          tal2 = tal1 + COUNT_W'(1);
        end
      end
    end
    if (bad_type) begin
      na2  = next_arg;
      tal2 = tally;
      kn2  = tally_known;
      e2   = ST_BADTYPE;
    end
  end

  always_comb begin
    mode_next          = mode;
    num_next           = num;
    arg_pos_next       = arg_pos;
    arg_pos_valid_next = arg_pos_valid;
    width_pos_next     = width_pos;
    width_kind_next    = width_kind;
    next_arg_next      = next_arg;
    tally_next         = tally;
    tally_known_next   = tally_known;
    err_code_next      = err_code;

    if (acc_char) begin
      unique case (mode)
        MODE_TEXT: begin
          if (c == CH_PCT) mode_next = MODE_PCT;
        end
        MODE_PCT, MODE_FLAGS: begin
          if (mode == MODE_PCT) begin
            arg_pos_valid_next = 1'b0;
            width_kind_next    = POS_NONE;
          end
          if ((mode == MODE_PCT) && (c == CH_PCT)) begin
            mode_next = MODE_TEXT;
          end else if ((mode == MODE_PCT) && is_dig) begin
            num_next  = dig_first;
            mode_next = MODE_NUM1;
          end else if (c == CH_MINUS) begin
            mode_next = MODE_FLAGS;
          end else if (c == CH_STAR) begin
            mode_next = MODE_STAR;
          end else if (is_dig) begin
            num_next  = dig_first;
            mode_next = MODE_WIDTH;
          end else begin
            mode_next        = MODE_TEXT;
            next_arg_next    = na2;
            tally_next       = tal2;
            tally_known_next = kn2;
            err_code_next    = e2;
          end
        end
        MODE_NUM1, MODE_WIDTH, MODE_STARNUM: begin
          if (is_dig) begin
            if (dig_ovf) err_code_next = ST_RANGE;
            else         num_next      = dig_sum[NUM_W-1:0];
          end else if ((mode == MODE_NUM1) && (c == CH_DOLLAR)) begin
            arg_pos_next       = num;
            arg_pos_valid_next = 1'b1;
            if (num == '0) err_code_next = ST_ZERO;
            else           mode_next     = MODE_FLAGS;
          end else if (mode == MODE_STARNUM) begin
            if (c != CH_DOLLAR) begin
              err_code_next = ST_NODOLLAR;
            end else begin
              width_pos_next  = num;
              width_kind_next = POS_EXPL;
              if (num == '0) err_code_next = ST_ZERO;
              else           mode_next     = MODE_TYPE;
            end
          end else begin
            mode_next        = MODE_TEXT;
            next_arg_next    = na2;
            tally_next       = tal2;
            tally_known_next = kn2;
            err_code_next    = e2;
          end
        end
        MODE_STAR: begin
          if (is_dig) begin
            num_next  = dig_first;
            mode_next = MODE_STARNUM;
          end else begin
            width_kind_next  = POS_IMPL;
            mode_next        = MODE_TEXT;
            next_arg_next    = na2;
            tally_next       = tal2;
            tally_known_next = kn2;
            err_code_next    = e2;
          end
        end
        MODE_TYPE: begin
          mode_next        = MODE_TEXT;
          next_arg_next    = na2;
          tally_next       = tal2;
          tally_known_next = kn2;
          err_code_next    = e2;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arg_count <= COUNT_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      arg_count <= cfg.arg_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || acc_end) begin
      mode          <= MODE_TEXT;
      num           <= '0;
      arg_pos       <= '0;
      arg_pos_valid <= 1'b0;
      width_pos     <= '0;
      width_kind    <= POS_NONE;
      next_arg      <= ARG_W'(1);
      tally         <= '0;
      tally_known   <= 1'b1;
      err_code      <= ST_OK;
    end else begin
      mode          <= mode_next;
      num           <= num_next;
      arg_pos       <= arg_pos_next;
      arg_pos_valid <= arg_pos_valid_next;
      width_pos     <= width_pos_next;
      width_kind    <= width_kind_next;
      next_arg      <= next_arg_next;
      tally         <= tally_next;
      tally_known   <= tally_known_next;
      err_code      <= err_code_next;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc_end) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_end) begin
      if (err_code != ST_OK) begin
        out_status <= err_code;
        out_known  <= 1'b0;
        out_count  <= '0;
      end else if (mode != MODE_TEXT) begin
        out_status <= ST_UNTERM;
        out_known  <= 1'b0;
        out_count  <= '0;
      end else begin
        out_known <= tally_known;
        out_count <= tally_known ? tally : '0;
        out_status <= (tally_known && ((ARG_W'(tally) + ARG_W'(1)) != ARG_W'(arg_count)))
                      ? ST_UNUSED : ST_OK;
      end
    end
  end

  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.required_known = out_known;
  assign result.required_count = out_count;

`ifndef ASSERT_OFF
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    acc_end |=> result.valid)
    else $error("end word did not produce a result");

  a_char_no_result: assert property (@(posedge clk) disable iff (rst)
    (acc && !chars.end_mark && !out_valid) |=> !result.valid)
    else $error("result produced without an end word");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    acc_end |=> (mode == MODE_TEXT) && (err_code == ST_OK) && (next_arg == ARG_W'(1)))
    else $error("parser not cleared after end word");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    ((err_code != ST_OK) && !acc_end) |=> $stable(err_code))
    else $error("error code changed before end word");

  a_unknown_count_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.required_known) |-> (result.required_count == '0))
    else $error("count reported while unknown");
`endif

endmodule
